// File: rtl/core/ctrm_pkg.sv
package ctrm_pkg;

    localparam logic [1:0] CMD_ENTRY = 2'd0;
    localparam logic [1:0] CMD_EXIT  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic CFG_TRACE_EN   = 1'b0;
    localparam logic CFG_PID_FILTER = 1'b1;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ENTRY,
        OP_EXIT,
        OP_CLEAR,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [31:0]        proc;
        logic [9:0]         call;
        logic [5:0][63:0]   args;
        logic signed [63:0] ret;
        logic [63:0]        stamp;
        logic [9:0]         idx;
    } t_item;

    typedef struct packed {
        logic [31:0]        proc;
        logic [9:0]         call;
        logic [5:0][63:0]   args;
        logic signed [63:0] ret;
        logic               done;
        logic [63:0]        stamp;
    } t_result;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_push;

endpackage

// File: rtl/core/call_trace_ring_matcher.sv
// Call trace ring of RING_DEPTH slots held in single-port-read block memories. Each word
// yields one result. An accepted word is registered in a two-word queue between the
// decoder and the ring engine, which lets input and output stall independently. In the
// ring engine, entry, clear, and filtered or disabled words finish in the idle state. A
// read passes through a read state because the memory read is registered. An exit probes
// slots newest to oldest in a search state. The search ends at the first match or
// after the fill count, and is skipped when the ring is empty. The ring memory read
// port checks one slot per cycle. There is no clearing pass after reset. A clear resets
// only the pointer and the fill count.
module call_trace_ring_matcher
    import ctrm_pkg::*;
#(
    parameter int RING_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_cmd,
    input  logic [31:0]        i_proc_id,
    input  logic [9:0]         i_call_number,
    input  logic [63:0]        i_arg_zero,
    input  logic [63:0]        i_arg_one,
    input  logic [63:0]        i_arg_two,
    input  logic [63:0]        i_arg_three,
    input  logic [63:0]        i_arg_four,
    input  logic [63:0]        i_arg_five,
    input  logic signed [63:0] i_return_value,
    input  logic [63:0]        i_stamp,
    input  logic [9:0]         i_slot_index,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [31:0]        o_slot_proc_id,
    output logic [9:0]         o_slot_call_number,
    output logic [63:0]        o_slot_arg_zero,
    output logic [63:0]        o_slot_arg_one,
    output logic [63:0]        o_slot_arg_two,
    output logic [63:0]        o_slot_arg_three,
    output logic [63:0]        o_slot_arg_four,
    output logic [63:0]        o_slot_arg_five,
    output logic signed [63:0] o_slot_return,
    output logic               o_done_flag,
    output logic [63:0]        o_slot_stamp,
    output logic [10:0]        o_fill_count
);

    t_push   push;
    t_item   q_item;
    t_result res;
    logic    q_full, q_valid, q_pop;

    ctrm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_proc_id      (i_proc_id),
        .i_call_number  (i_call_number),
        .i_args         ({i_arg_five, i_arg_four, i_arg_three,
                          i_arg_two, i_arg_one, i_arg_zero}),
        .i_return_value (i_return_value),
        .i_stamp        (i_stamp),
        .i_slot_index   (i_slot_index),
        .i_q_full       (q_full),
        .o_push         (push)
    );

    ctrm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (q_item)
    );

    ctrm_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_item       (q_item),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_res        (res),
        .o_fill_count (o_fill_count)
    );

    assign o_slot_proc_id     = res.proc;
    assign o_slot_call_number = res.call;
    assign o_slot_arg_zero    = res.args[0];
    assign o_slot_arg_one     = res.args[1];
    assign o_slot_arg_two     = res.args[2];
    assign o_slot_arg_three   = res.args[3];
    assign o_slot_arg_four    = res.args[4];
    assign o_slot_arg_five    = res.args[5];
    assign o_slot_return      = res.ret;
    assign o_done_flag        = res.done;
    assign o_slot_stamp       = res.stamp;

endmodule

// File: rtl/core/ctrm_front.sv
module ctrm_front
    import ctrm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_cmd,
    input  logic [31:0]        i_proc_id,
    input  logic [9:0]         i_call_number,
    input  logic [5:0][63:0]   i_args,
    input  logic signed [63:0] i_return_value,
    input  logic [63:0]        i_stamp,
    input  logic [9:0]         i_slot_index,
    input  logic               i_q_full,
    output t_push              o_push
);

    logic        r_trace_en;
    logic [31:0] r_pid_filter;
    logic        pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trace_en   <= 1'b0;
            r_pid_filter <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TRACE_EN:   r_trace_en   <= i_cfg_data[0];
                CFG_PID_FILTER: r_pid_filter <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign pass       = (r_pid_filter == 32'd0) || (i_proc_id == r_pid_filter);
    assign o_in_ready = !i_q_full;

    always_comb begin
        o_push.valid      = i_in_valid && !i_q_full;
        o_push.item.proc  = i_proc_id;
        o_push.item.call  = i_call_number;
        o_push.item.args  = i_args;
        o_push.item.ret   = i_return_value;
        o_push.item.stamp = i_stamp;
        o_push.item.idx   = i_slot_index;
        case (i_cmd)
            CMD_ENTRY: o_push.item.op = (r_trace_en && pass) ? OP_ENTRY : OP_NOP;
            CMD_EXIT:  o_push.item.op = r_trace_en ? OP_EXIT : OP_NOP;
            CMD_CLEAR: o_push.item.op = OP_CLEAR;
            CMD_READ:  o_push.item.op = OP_READ;
            default:   o_push.item.op = OP_NOP;
        endcase
    end

endmodule

// File: rtl/core/ctrm_queue.sv
module ctrm_queue
    import ctrm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_full,
    output logic  o_valid,
    input  logic  i_pop,
    output t_item o_item
);

    t_item       r_mem [2];
    logic        r_rp;
    logic        r_wp;
    logic [1:0]  r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wp] <= i_push.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp  <= 1'b0;
            r_wp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push.valid) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push.valid) - 2'(i_pop);
        end
    end

endmodule

// File: rtl/core/ctrm_back.sv
module ctrm_back
    import ctrm_pkg::*;
#(
    parameter int RING_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_result     o_res,
    output logic [10:0] o_fill_count
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD,
        ST_SRCH
    } t_state;

    logic [41:0]  id_mem  [RING_DEPTH];
    logic [447:0] pay_mem [RING_DEPTH];
    logic [64:0]  ret_mem [RING_DEPTH];

    logic [41:0]  id_rd;
    logic [447:0] pay_rd;
    logic [64:0]  ret_rd;

    t_state             r_st, n_st;
    logic [AW-1:0]      r_wp, n_wp;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [CW-1:0]      r_iss, n_iss;
    logic [AW-1:0]      r_paddr, n_paddr;
    logic [41:0]        r_key, n_key;
    logic signed [63:0] r_kret, n_kret;
    logic               r_ov, n_ov;
    t_result            r_res, n_res;

    logic          id_we, pay_we, ret_we;
    logic [AW-1:0] ret_wa, rd_addr;
    logic [64:0]   ret_wd;
    logic          can_issue, match;
    logic [AW+9:0] idx_ext;
    logic [CW+10:0] cnt_ext;

    function automatic logic [AW-1:0] dec(input logic [AW-1:0] a);
        return (a == '0) ? AW'(RING_DEPTH - 1) : a - AW'(1);
    endfunction

    assign idx_ext      = {{AW{1'b0}}, i_item.idx};
    assign cnt_ext      = {11'd0, r_cnt};
    assign o_fill_count = cnt_ext[10:0];
    assign can_issue    = !r_ov || i_out_ready;
    assign o_pop        = (r_st == ST_IDLE) && can_issue && i_q_valid;
    assign match        = (id_rd == r_key) && !ret_rd[64];
    assign o_out_valid  = r_ov;
    assign o_res        = r_res;

    always_ff @(posedge i_clk) begin
        if (id_we) begin
            id_mem[r_wp] <= {i_item.call, i_item.proc};
        end
        if (pay_we) begin
            pay_mem[r_wp] <= {i_item.stamp, i_item.args};
        end
        if (ret_we) begin
            ret_mem[ret_wa] <= ret_wd;
        end
        id_rd  <= id_mem[rd_addr];
        pay_rd <= pay_mem[rd_addr];
        ret_rd <= ret_mem[rd_addr];
    end

    always_comb begin
        n_st    = r_st;
        n_wp    = r_wp;
        n_cnt   = r_cnt;
        n_iss   = r_iss;
        n_paddr = r_paddr;
        n_key   = r_key;
        n_kret  = r_kret;
        n_ov    = r_ov && !i_out_ready;
        n_res   = r_res;
        id_we   = 1'b0;
        pay_we  = 1'b0;
        ret_we  = 1'b0;
        ret_wa  = r_wp;
        ret_wd  = '0;
        rd_addr = r_paddr;
        case (r_st)
            ST_IDLE: begin
                if (o_pop) begin
                    n_res = '0;
                    case (i_item.op)
                        OP_ENTRY: begin
                            id_we  = 1'b1;
                            pay_we = 1'b1;
                            ret_we = 1'b1;
                            n_wp   = (r_wp == AW'(RING_DEPTH - 1)) ? '0 : r_wp + AW'(1);
                            if (r_cnt != CW'(RING_DEPTH)) begin
                                n_cnt = r_cnt + CW'(1);
                            end
                            n_ov = 1'b1;
                        end
                        OP_EXIT: begin
                            if (r_cnt == '0) begin
                                n_ov = 1'b1;
                            end else begin
                                rd_addr = dec(r_wp);
                                n_paddr = dec(r_wp);
                                n_iss   = CW'(1);
                                n_key   = {i_item.call, i_item.proc};
                                n_kret  = i_item.ret;
                                n_st    = ST_SRCH;
                            end
                        end
                        OP_CLEAR: begin
                            n_wp  = '0;
                            n_cnt = '0;
                            n_ov  = 1'b1;
                        end
                        OP_READ: begin
                            if (32'(i_item.idx) < 32'(RING_DEPTH)) begin
                                rd_addr = idx_ext[AW-1:0];
                                n_st    = ST_RD;
                            end else begin
                                n_ov = 1'b1;
                            end
                        end
                        default: n_ov = 1'b1;
                    endcase
                end
            end
            ST_RD: begin
                n_res.proc  = id_rd[31:0];
                n_res.call  = id_rd[41:32];
                n_res.args  = pay_rd[383:0];
                n_res.stamp = pay_rd[447:384];
                n_res.ret   = ret_rd[63:0];
                n_res.done  = ret_rd[64];
                n_ov        = 1'b1;
                n_st        = ST_IDLE;
            end
            ST_SRCH: begin
                if (match) begin
                    ret_we     = 1'b1;
                    ret_wa     = r_paddr;
                    ret_wd     = {1'b1, r_kret};
                    n_res.done = 1'b1;
                    n_ov       = 1'b1;
                    n_st       = ST_IDLE;
                end else if (r_iss == r_cnt) begin
                    n_ov = 1'b1;
                    n_st = ST_IDLE;
                end else begin
                    rd_addr = dec(r_paddr);
                    n_paddr = dec(r_paddr);
                    n_iss   = r_iss + CW'(1);
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= ST_IDLE;
            r_wp  <= '0;
            r_cnt <= '0;
            r_iss <= '0;
            r_ov  <= 1'b0;
        end else begin
            r_st  <= n_st;
            r_wp  <= n_wp;
            r_cnt <= n_cnt;
            r_iss <= n_iss;
            r_ov  <= n_ov;
        end
        r_paddr <= n_paddr;
        r_key   <= n_key;
        r_kret  <= n_kret;
        r_res   <= n_res;
    end

`ifndef ASSERT_OFF
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(RING_DEPTH))
        else $error("fill count above depth");
    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_wp) < 32'(RING_DEPTH))
        else $error("write pointer out of range");
    a_srch_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_SRCH) |-> (r_iss != '0 && r_iss <= r_cnt))
        else $error("search probe count out of range");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_item.op == OP_CLEAR) |=> (r_cnt == '0 && r_wp == '0))
        else $error("clear did not empty ring");
    a_busy_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != ST_IDLE) |-> !r_ov)
        else $error("result pending during ring access");
`endif

endmodule
